FILE: sv/masked_affine_color_matrix_defines.svh
// Assertion macros for the color matrix block.
// Included by the top level; depends on nothing else.
`ifndef MASKED_AFFINE_COLOR_MATRIX_DEFINES_SVH
`define MASKED_AFFINE_COLOR_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CMAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CMAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cmat_pkg.sv
// Shared types and constants for the color matrix block.
// No dependencies.
package cmat_pkg;

  localparam int DATA_W        = 32;
  localparam int ROWS          = 4;
  localparam int COLS          = 5;
  localparam int OFF_COL       = 4;
  localparam int STORE_DEPTH   = ROWS * COLS;
  localparam int MASK_W        = STORE_DEPTH;
  localparam int IDX_W         = 5;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [MASK_W-1:0]        mask_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_COEF  = 1'b1
  } mode_t;

  // Pipeline control handed to the multiplier stage.
  typedef struct packed {
    logic adv;
    logic take_pixel;
  } pipe_ctl_t;

endpackage

FILE: sv/masked_affine_color_matrix.sv
// Top level of the masked 4x5 affine color matrix.
// Depends on cmat_pkg, cmat_coef_store, cmat_mul, cmat_term, cmat_acc and
// masked_affine_color_matrix_defines.svh.
//
// Takes one item per clock, with no bubbles, whenever the result side is not
// stalling. A pixel item (mode 0) passes through four register stages: the
// multiplier array of sixteen 32x32 products, mask selection with paired adds,
// the final row add, and saturation into the output register. The first stage
// loads at the edge that accepts the pixel, and the item then moves through the
// paired-add, row-sum and output registers in turn. A coefficient item (mode 1)
// is written into the store at the edge it is accepted and gives no result; a
// pixel item uses the store as it stands when the pixel is accepted, so
// coefficient writes and pixels may be freely interleaved. The whole pipeline
// advances whenever the output register is empty or its item is taken; a stall
// on the result side while a result waits holds every stage and raises in_stall
// in the same cycle, so nothing is lost or repeated. Write term_enable_mask only
// while no pixel is in flight.
`include "masked_affine_color_matrix_defines.svh"

module masked_affine_color_matrix #(
  parameter int FRAC_BITS = cmat_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [cmat_pkg::MASK_W-1:0] cfg_wr_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [0:0]              in_mode,
  input  logic [cmat_pkg::IDX_W-1:0] in_coef_index,
  input  logic signed [cmat_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [cmat_pkg::DATA_W-1:0] in_comp_a,
  input  logic signed [cmat_pkg::DATA_W-1:0] in_comp_b,
  input  logic signed [cmat_pkg::DATA_W-1:0] in_comp_c,
  input  logic signed [cmat_pkg::DATA_W-1:0] in_comp_d,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [cmat_pkg::DATA_W-1:0] out_res_a,
  output logic signed [cmat_pkg::DATA_W-1:0] out_res_b,
  output logic signed [cmat_pkg::DATA_W-1:0] out_res_c,
  output logic signed [cmat_pkg::DATA_W-1:0] out_res_d
);

  localparam int SUM_W = cmat_pkg::PROD_W - FRAC_BITS + 3;

  cmat_pkg::mask_t     mask_r;
  cmat_pkg::pipe_ctl_t ctl;
  logic                adv;
  logic                coef_wr;
  logic                out_valid_r;

  cmat_pkg::word_t comp [cmat_pkg::ROWS];
  cmat_pkg::word_t coef [cmat_pkg::STORE_DEPTH];

  logic                               mul_v;
  logic signed [cmat_pkg::PROD_W-1:0] mul_prod [cmat_pkg::ROWS*cmat_pkg::ROWS];
  cmat_pkg::word_t                    mul_comp [cmat_pkg::ROWS];
  cmat_pkg::word_t                    mul_off [cmat_pkg::ROWS];

  logic                    term_v;
  logic signed [SUM_W-1:0] term_s01 [cmat_pkg::ROWS];
  logic signed [SUM_W-1:0] term_s23 [cmat_pkg::ROWS];
  logic signed [SUM_W-1:0] term_off [cmat_pkg::ROWS];

  cmat_pkg::word_t res [cmat_pkg::ROWS];

  // Enable mask register; the user must write it only while idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  // Advance every stage unless a finished item sits stalled at the output.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Write coefficients at acceptance; launch pixels into stage 1.
  assign coef_wr = in_valid && adv && (in_mode == cmat_pkg::MODE_COEF);
  assign ctl     = '{adv: adv, take_pixel: in_valid && (in_mode == cmat_pkg::MODE_PIXEL)};

  assign comp[0] = in_comp_a;
  assign comp[1] = in_comp_b;
  assign comp[2] = in_comp_c;
  assign comp[3] = in_comp_d;

  cmat_coef_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_wr),
    .wr_idx  (in_coef_index),
    .wr_data (in_coef_value),
    .coef    (coef)
  );

  cmat_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .comp   (comp),
    .coef   (coef),
    .v_r    (mul_v),
    .prod_r (mul_prod),
    .comp_r (mul_comp),
    .off_r  (mul_off)
  );

  cmat_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .v_in  (mul_v),
    .mask  (mask_r),
    .prod  (mul_prod),
    .comp  (mul_comp),
    .off   (mul_off),
    .v_r   (term_v),
    .s01_r (term_s01),
    .s23_r (term_s23),
    .off_r (term_off)
  );

  cmat_acc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .v_in        (term_v),
    .s01         (term_s01),
    .s23         (term_s23),
    .off         (term_off),
    .out_valid_r (out_valid_r),
    .res_r       (res)
  );

  assign out_valid = out_valid_r;
  assign out_res_a = res[0];
  assign out_res_b = res[1];
  assign out_res_c = res[2];
  assign out_res_d = res[3];

  // A coefficient item must never enter the result pipeline.
  `CMAT_ASSERT_NEXT(a_coef_no_result, clk, rst_n, in_valid && !in_stall && (in_mode == cmat_pkg::MODE_COEF), !mul_v, "coefficient item entered the pipeline")

  // A pixel that meets no stall on its way through the stages reaches the output.
  `CMAT_ASSERT_NEXT(a_pixel_latency, clk, rst_n, (in_valid && !in_stall && (in_mode == cmat_pkg::MODE_PIXEL)) ##1 !in_stall ##1 !in_stall ##1 !in_stall, out_valid, "pixel result missing after four stages")

  // An accepted pixel is in stage 1 at the next edge.
  `CMAT_ASSERT_NEXT(a_pixel_launch, clk, rst_n, in_valid && !in_stall && (in_mode == cmat_pkg::MODE_PIXEL), mul_v, "pixel item not launched")

endmodule

FILE: sv/cmat_coef_store.sv
// Coefficient store: 20 signed words, cleared by reset, one write per cycle.
// Depends on cmat_pkg.
module cmat_coef_store (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  cmat_pkg::idx_t        wr_idx,
  input  cmat_pkg::word_t       wr_data,
  output cmat_pkg::word_t       coef [cmat_pkg::STORE_DEPTH]
);

  cmat_pkg::word_t coef_r [cmat_pkg::STORE_DEPTH];

  // Indexes past the last entry match nothing and drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cmat_pkg::STORE_DEPTH; i++) begin
        coef_r[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < cmat_pkg::STORE_DEPTH; i++) begin
        if (wr_idx == cmat_pkg::IDX_W'(i)) begin
          coef_r[i] <= wr_data;
        end
      end
    end
  end

  assign coef = coef_r;

endmodule

FILE: sv/cmat_mul.sv
// Stage 1: sixteen 32x32 signed multipliers, plus capture of the pixel and offsets.
// Depends on cmat_pkg.
module cmat_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmat_pkg::pipe_ctl_t           ctl,
  input  cmat_pkg::word_t               comp [cmat_pkg::ROWS],
  input  cmat_pkg::word_t               coef [cmat_pkg::STORE_DEPTH],
  output logic                          v_r,
  output logic signed [cmat_pkg::PROD_W-1:0] prod_r [cmat_pkg::ROWS*cmat_pkg::ROWS],
  output cmat_pkg::word_t               comp_r [cmat_pkg::ROWS],
  output cmat_pkg::word_t               off_r [cmat_pkg::ROWS]
);

  logic signed [cmat_pkg::PROD_W-1:0] prod_nxt [cmat_pkg::ROWS*cmat_pkg::ROWS];

  always_comb begin
    for (int r = 0; r < cmat_pkg::ROWS; r++) begin
      for (int c = 0; c < cmat_pkg::ROWS; c++) begin
        prod_nxt[r*cmat_pkg::ROWS+c] =
          cmat_pkg::PROD_W'(coef[r*cmat_pkg::COLS+c]) * cmat_pkg::PROD_W'(comp[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctl.adv) begin
      v_r <= ctl.take_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int k = 0; k < cmat_pkg::ROWS*cmat_pkg::ROWS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      for (int r = 0; r < cmat_pkg::ROWS; r++) begin
        comp_r[r] <= comp[r];
        off_r[r]  <= coef[r*cmat_pkg::COLS+cmat_pkg::OFF_COL];
      end
    end
  end

endmodule

FILE: sv/cmat_term.sv
// Stage 2: floor-shift products, apply the enable mask, add terms in pairs.
// Depends on cmat_pkg.
module cmat_term #(
  parameter int FRAC_BITS = cmat_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          v_in,
  input  cmat_pkg::mask_t               mask,
  input  logic signed [cmat_pkg::PROD_W-1:0] prod [cmat_pkg::ROWS*cmat_pkg::ROWS],
  input  cmat_pkg::word_t               comp [cmat_pkg::ROWS],
  input  cmat_pkg::word_t               off [cmat_pkg::ROWS],
  output logic                          v_r,
  output logic signed [cmat_pkg::PROD_W-FRAC_BITS+2:0] s01_r [cmat_pkg::ROWS],
  output logic signed [cmat_pkg::PROD_W-FRAC_BITS+2:0] s23_r [cmat_pkg::ROWS],
  output logic signed [cmat_pkg::PROD_W-FRAC_BITS+2:0] off_r [cmat_pkg::ROWS]
);

  localparam int TERM_W = cmat_pkg::PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 3;

  logic signed [TERM_W-1:0] term [cmat_pkg::ROWS][cmat_pkg::ROWS];
  logic signed [SUM_W-1:0]  s01_nxt [cmat_pkg::ROWS];
  logic signed [SUM_W-1:0]  s23_nxt [cmat_pkg::ROWS];
  logic signed [SUM_W-1:0]  off_nxt [cmat_pkg::ROWS];

  // Disabled diagonal passes the component; disabled off-diagonal gives zero.
  always_comb begin
    for (int r = 0; r < cmat_pkg::ROWS; r++) begin
      for (int c = 0; c < cmat_pkg::ROWS; c++) begin
        if (mask[r*cmat_pkg::COLS+c]) begin
          term[r][c] = TERM_W'(prod[r*cmat_pkg::ROWS+c] >>> FRAC_BITS);
        end else if (r == c) begin
          term[r][c] = TERM_W'(comp[c]);
        end else begin
          term[r][c] = '0;
        end
      end
      s01_nxt[r] = SUM_W'(term[r][0]) + SUM_W'(term[r][1]);
      s23_nxt[r] = SUM_W'(term[r][2]) + SUM_W'(term[r][3]);
      off_nxt[r] = mask[r*cmat_pkg::COLS+cmat_pkg::OFF_COL] ? SUM_W'(off[r]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s01_r <= s01_nxt;
      s23_r <= s23_nxt;
      off_r <= off_nxt;
    end
  end

endmodule

FILE: sv/cmat_acc.sv
// Stages 3 and 4: final row sum, then saturation into the output register.
// Depends on cmat_pkg.
module cmat_acc #(
  parameter int FRAC_BITS = cmat_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          v_in,
  input  logic signed [cmat_pkg::PROD_W-FRAC_BITS+2:0] s01 [cmat_pkg::ROWS],
  input  logic signed [cmat_pkg::PROD_W-FRAC_BITS+2:0] s23 [cmat_pkg::ROWS],
  input  logic signed [cmat_pkg::PROD_W-FRAC_BITS+2:0] off [cmat_pkg::ROWS],
  output logic                          out_valid_r,
  output cmat_pkg::word_t               res_r [cmat_pkg::ROWS]
);

  localparam int SUM_W = cmat_pkg::PROD_W - FRAC_BITS + 3;
  localparam int HI_W  = SUM_W - cmat_pkg::DATA_W + 1;

  logic                    v3_r;
  logic signed [SUM_W-1:0] sum_r [cmat_pkg::ROWS];
  logic signed [SUM_W-1:0] sum_nxt [cmat_pkg::ROWS];
  cmat_pkg::word_t         res_nxt [cmat_pkg::ROWS];
  logic [HI_W-1:0]         hi [cmat_pkg::ROWS];

  always_comb begin
    for (int r = 0; r < cmat_pkg::ROWS; r++) begin
      sum_nxt[r] = s01[r] + s23[r] + off[r];
    end
  end

  // Clamp when the bits above the result width disagree with its sign bit.
  always_comb begin
    for (int r = 0; r < cmat_pkg::ROWS; r++) begin
      hi[r] = sum_r[r][SUM_W-1:cmat_pkg::DATA_W-1];
      if ((&hi[r]) || !(|hi[r])) begin
        res_nxt[r] = sum_r[r][cmat_pkg::DATA_W-1:0];
      end else if (sum_r[r][SUM_W-1]) begin
        res_nxt[r] = {1'b1, {(cmat_pkg::DATA_W-1){1'b0}}};
      end else begin
        res_nxt[r] = {1'b0, {(cmat_pkg::DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v3_r        <= v_in;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

FILE: verif/tb.sv
// Self-checking bench for masked_affine_color_matrix: a queue-fed driver, a result
// monitor and a bit-exact predictor of the masked 4x5 Q16.16 affine transform.
// Depends on cmat_pkg and the block's RTL only.
module tb;

  localparam int FRAC            = cmat_pkg::FRAC_BITS_DEF;
  localparam int HOLD_OFF_CYCLES = 80;    // long receiver stall to back the pipe up
  localparam int DRAIN_CYCLES    = 8;     // four stages plus margin
  localparam int WATCHDOG_LIMIT  = 1000;  // far above any quiet stretch of a good run
  localparam int PHASE_ITEMS     = 175;
  localparam int ROWS            = cmat_pkg::ROWS;
  localparam int DATA_W          = cmat_pkg::DATA_W;

  localparam cmat_pkg::word_t Q_MAX = 32'sh7FFF_FFFF;
  localparam cmat_pkg::word_t Q_MIN = 32'sh8000_0000;
  localparam cmat_pkg::word_t Q_ONE = 32'sh0001_0000;
  localparam cmat_pkg::word_t Q_NEG_ONE_LSB = -32'sd1;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Diagonal term bits (r*5+r) and offset bits (r*5+4) of the enable mask.
  localparam cmat_pkg::mask_t DIAG_BITS   = 20'h41041;
  localparam cmat_pkg::mask_t OFFSET_BITS = 20'h84210;

  typedef struct packed {
    cmat_pkg::mode_t mode;
    cmat_pkg::idx_t  idx;
    cmat_pkg::word_t coef;
    cmat_pkg::word_t comp_a;
    cmat_pkg::word_t comp_b;
    cmat_pkg::word_t comp_c;
    cmat_pkg::word_t comp_d;
  } matrix_item_t;

  typedef struct packed {
    cmat_pkg::word_t res_a;
    cmat_pkg::word_t res_b;
    cmat_pkg::word_t res_c;
    cmat_pkg::word_t res_d;
  } pixel_result_t;

  // Every DUT input starts at a known value.
  logic            clk           = 1'b0;
  logic            rst_n         = 1'b0;
  logic            cfg_wr_en     = 1'b0;
  cmat_pkg::mask_t cfg_wr_data   = '0;
  logic            in_valid      = 1'b0;
  logic            in_stall;
  logic [0:0]      in_mode       = cmat_pkg::MODE_PIXEL;
  cmat_pkg::idx_t  in_coef_index = '0;
  cmat_pkg::word_t in_coef_value = '0;
  cmat_pkg::word_t in_comp_a     = '0;
  cmat_pkg::word_t in_comp_b     = '0;
  cmat_pkg::word_t in_comp_c     = '0;
  cmat_pkg::word_t in_comp_d     = '0;
  logic            out_valid;
  logic            out_stall     = 1'b0;
  cmat_pkg::word_t out_res_a;
  cmat_pkg::word_t out_res_b;
  cmat_pkg::word_t out_res_c;
  cmat_pkg::word_t out_res_d;

  // Predictor state: the coefficient bank and enable mask as the block holds them.
  cmat_pkg::word_t coef_bank [cmat_pkg::STORE_DEPTH];
  cmat_pkg::mask_t term_mask;

  matrix_item_t  queued_items [$];
  pixel_result_t expected_pixels [$];
  matrix_item_t  on_port;
  pixel_result_t seen_pixel;
  pixel_result_t want_pixel;
  string         field_name [ROWS] = '{"res_a", "res_b", "res_c", "res_d"};

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  bit hold_off_armed  = 1'b0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  int items_queued    = 0;
  int pixels_sent     = 0;
  int coef_writes     = 0;
  int coefs_ignored   = 0;
  int pixels_checked  = 0;
  int mask_writes     = 0;
  int mismatch_count  = 0;

  masked_affine_color_matrix DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_comp_a     (in_comp_a),
    .in_comp_b     (in_comp_b),
    .in_comp_c     (in_comp_c),
    .in_comp_d     (in_comp_d),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res_a     (out_res_a),
    .out_res_b     (out_res_b),
    .out_res_c     (out_res_c),
    .out_res_d     (out_res_d)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Transform one pixel against the bank and mask as they stand at acceptance.
  // Each enabled product is exact, then floored by FRAC bits; a disabled
  // diagonal passes its component straight in; the row sum saturates once.
  function automatic pixel_result_t transform_pixel(matrix_item_t it);
    longint          comp [ROWS];
    longint          acc;
    cmat_pkg::word_t row_out [ROWS];
    int              r;
    int              c;
    int              tap;
    comp[0] = it.comp_a;
    comp[1] = it.comp_b;
    comp[2] = it.comp_c;
    comp[3] = it.comp_d;
    for (r = 0; r < ROWS; r++) begin
      acc = 0;
      for (c = 0; c < ROWS; c++) begin
        tap = r * cmat_pkg::COLS + c;
        if (term_mask[tap]) begin
          acc += (longint'(coef_bank[tap]) * comp[c]) >>> FRAC;
        end else if (c == r) begin
          acc += comp[c];
        end
      end
      tap = r * cmat_pkg::COLS + cmat_pkg::OFF_COL;
      if (term_mask[tap]) acc += longint'(coef_bank[tap]);
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      row_out[r] = cmat_pkg::word_t'(acc);
    end
    return '{row_out[0], row_out[1], row_out[2], row_out[3]};
  endfunction

  function automatic void queue_item(matrix_item_t it);
    queued_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void push_coef(cmat_pkg::idx_t idx, cmat_pkg::word_t val);
    matrix_item_t it;
    it      = '0;
    it.mode = cmat_pkg::MODE_COEF;
    it.idx  = idx;
    it.coef = val;
    queue_item(it);
  endfunction

  function automatic void push_pixel(cmat_pkg::word_t a, cmat_pkg::word_t b,
                                     cmat_pkg::word_t c, cmat_pkg::word_t d);
    matrix_item_t it;
    it        = '0;
    it.mode   = cmat_pkg::MODE_PIXEL;
    it.comp_a = a;
    it.comp_b = b;
    it.comp_c = c;
    it.comp_d = d;
    queue_item(it);
  endfunction

  // Mix rails, small Q16.16 values (within +-8.0) and raw 32-bit patterns.
  function automatic cmat_pkg::word_t rand_word();
    case ($urandom_range(7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return Q_NEG_ONE_LSB;
      4, 5:    return cmat_pkg::word_t'($urandom_range(32'h0010_0000))
                      - cmat_pkg::word_t'(32'h0008_0000);
      default: return cmat_pkg::word_t'($urandom);
    endcase
  endfunction

  // Roughly seven pixels per three coefficient writes; one write in eight misses the bank.
  function automatic matrix_item_t random_item();
    matrix_item_t it;
    it.mode   = ($urandom_range(99) < 30) ? cmat_pkg::MODE_COEF : cmat_pkg::MODE_PIXEL;
    it.idx    = ($urandom_range(7) == 0)
                ? cmat_pkg::idx_t'($urandom_range(31, cmat_pkg::STORE_DEPTH))
                : cmat_pkg::idx_t'($urandom_range(cmat_pkg::STORE_DEPTH - 1));
    it.coef   = rand_word();
    it.comp_a = rand_word();
    it.comp_b = rand_word();
    it.comp_c = rand_word();
    it.comp_d = rand_word();
    return it;
  endfunction

  // Wait until every queued item is taken and every pixel has come back, then
  // let the pipe settle so nothing is in flight before the mask changes.
  task automatic wait_drained();
    while (coef_writes + pixels_sent != items_queued || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_term_mask(cmat_pkg::mask_t m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    term_mask = m;
    mask_writes++;
  endtask

  // Driver: on an accepted item, update the predictor (bank write or expected
  // pixel); then hold a stalled item, or present the next queued one unless
  // the sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (on_port.mode == cmat_pkg::MODE_COEF) begin
          coef_writes++;
          if (on_port.idx < cmat_pkg::STORE_DEPTH) coef_bank[on_port.idx] = on_port.coef;
          else coefs_ignored++;
        end else begin
          expected_pixels.push_back(transform_pixel(on_port));
          pixels_sent++;
        end
      end
      if (!(in_valid && in_stall)) begin
        if (queued_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          on_port = queued_items.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= on_port.mode;
          in_coef_index <= on_port.idx;
          in_coef_value <= on_port.coef;
          in_comp_a     <= on_port.comp_a;
          in_comp_b     <= on_port.comp_b;
          in_comp_c     <= on_port.comp_c;
          in_comp_d     <= on_port.comp_d;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest expected pixel, field
  // by field; then pick the stall for the next cycle. An armed hold-off
  // overrides the random stall until its hold_left countdown runs out.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result arrived with no pixel pending");
        end else begin
          seen_pixel = {out_res_a, out_res_b, out_res_c, out_res_d};
          want_pixel = expected_pixels.pop_front();
          for (int k = 0; k < ROWS; k++) begin
            if (seen_pixel[(ROWS-1-k)*DATA_W +: DATA_W] !==
                want_pixel[(ROWS-1-k)*DATA_W +: DATA_W])
              report_mismatch($sformatf("pixel %0d %s: got %h, want %h", pixels_checked,
                field_name[k], seen_pixel[(ROWS-1-k)*DATA_W +: DATA_W],
                want_pixel[(ROWS-1-k)*DATA_W +: DATA_W]));
          end
          pixels_checked++;
        end
      end
      if (hold_off_armed) begin
        hold_left      = HOLD_OFF_CYCLES;
        hold_off_armed = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (coef_bank[i]) coef_bank[i] = '0;
    term_mask = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset mask: every row is a pass-through, and writes past the bank are dropped.
    push_pixel(Q_MIN, Q_MAX, '0, Q_NEG_ONE_LSB);
    push_coef(cmat_pkg::idx_t'(20), 32'sh1234_5678);
    push_coef(cmat_pkg::idx_t'(31), Q_MAX);
    push_coef(cmat_pkg::idx_t'(0), 32'sh0002_0000);
    push_pixel(Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
    wait_drained();

    // All terms on: drive rows into both saturation rails and a floored -1 LSB.
    write_term_mask('1);
    push_coef(cmat_pkg::idx_t'(0), Q_MAX);
    push_coef(cmat_pkg::idx_t'(1), Q_MIN);
    push_coef(cmat_pkg::idx_t'(4), Q_MAX);
    push_coef(cmat_pkg::idx_t'(5), Q_NEG_ONE_LSB);
    push_coef(cmat_pkg::idx_t'(6), Q_ONE);
    push_coef(cmat_pkg::idx_t'(15), Q_MIN);
    push_coef(cmat_pkg::idx_t'(19), Q_MIN);
    push_pixel(Q_MAX, Q_MAX, '0, '0);
    push_pixel(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    push_pixel(32'sd1, 32'sd1, 32'sd1, 32'sd1);
    push_pixel(Q_NEG_ONE_LSB, 32'sh0001_8000, -32'sh0000_8000, Q_ONE);
    wait_drained();

    // Diagonals and offsets off: each component passes straight into its own row's diagonal term.
    write_term_mask('1 & ~(DIAG_BITS | OFFSET_BITS));
    push_pixel(Q_MAX, Q_MIN, 32'sh0001_2345, -32'sh0005_4321);
    push_coef(cmat_pkg::idx_t'(12), 32'sh0003_0000);
    push_pixel(Q_MAX, Q_MIN, 32'sh0001_2345, -32'sh0005_4321);
    wait_drained();

    // Random phases: no idling with one long hold-off, sender gaps, receiver
    // stalls, then both; the mask moves between all-on, all-off and random.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
          write_term_mask('1);
          hold_off_armed  = 1'b1;
        end
        1: begin
          sender_idle_pct = 68;
          stall_pct       = 0;
          write_term_mask(cmat_pkg::mask_t'($urandom));
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 68;
          write_term_mask('0);
        end
        default: begin
          sender_idle_pct = 32;
          stall_pct       = 32;
          write_term_mask(cmat_pkg::mask_t'($urandom));
        end
      endcase
      repeat (PHASE_ITEMS) queue_item(random_item());
      wait_drained();
    end

    $display("Run covered %0d pixels and %0d coefficient writes (%0d outside the bank)",
             pixels_sent, coef_writes, coefs_ignored);
    $display("across %0d mask settings with gaps, stalls and a long hold-off; %0d results",
             mask_writes, pixels_checked);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
